// ----- hdl/grp_pkg.sv -----
package grp_pkg;

  // one input word: a text byte and the start-of-file mark
  typedef struct packed {
    logic [7:0] byte_req;
    logic       start_of_file;
  } in_word_t;

  // one parsed record
  typedef struct packed {
    logic signed [31:0] rsid;
    logic               is_internal;
    logic [2:0]         chromosome_kind;
    logic [7:0]         chromosome_number;
    logic [31:0]        position;
    logic [2:0]         allele_first;
    logic [2:0]         allele_second;
    logic               y_seen;
  } out_word_t;

  // chromosome kind codes
  localparam logic [2:0] KIND_NUM = 3'd0;
  localparam logic [2:0] KIND_X   = 3'd1;
  localparam logic [2:0] KIND_Y   = 3'd2;
  localparam logic [2:0] KIND_MT  = 3'd3;
  localparam logic [2:0] KIND_UNK = 3'd4;

  // allele codes
  localparam logic [2:0] ALLELE_NONE = 3'd0;
  localparam logic [2:0] ALLELE_A    = 3'd1;
  localparam logic [2:0] ALLELE_C    = 3'd2;
  localparam logic [2:0] ALLELE_D    = 3'd3;
  localparam logic [2:0] ALLELE_G    = 3'd4;
  localparam logic [2:0] ALLELE_I    = 3'd5;
  localparam logic [2:0] ALLELE_T    = 3'd6;

  // characters
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_C  = 8'h43;
  localparam logic [7:0] CH_UP_D  = 8'h44;
  localparam logic [7:0] CH_UP_G  = 8'h47;
  localparam logic [7:0] CH_UP_I  = 8'h49;
  localparam logic [7:0] CH_UP_M  = 8'h4d;
  localparam logic [7:0] CH_UP_T  = 8'h54;
  localparam logic [7:0] CH_UP_X  = 8'h58;
  localparam logic [7:0] CH_UP_Y  = 8'h59;
  localparam logic [7:0] CH_LO_I  = 8'h69;
  localparam logic [7:0] CH_LO_R  = 8'h72;

  // parser phases, one-hot
  typedef enum logic [14:0] {
    PH_LINE     = 15'h0001,
    PH_SKIPLINE = 15'h0002,
    PH_PREFIX   = 15'h0004,
    PH_ID       = 15'h0008,
    PH_WS1      = 15'h0010,
    PH_CHROM    = 15'h0020,
    PH_CHROMNUM = 15'h0040,
    PH_SKIPT    = 15'h0080,
    PH_WS2      = 15'h0100,
    PH_POS      = 15'h0200,
    PH_WS3      = 15'h0400,
    PH_ALLELE1  = 15'h0800,
    PH_ALLELE2  = 15'h1000,
    PH_DISCARD  = 15'h2000,
    PH_END      = 15'h4000
  } phase_e;

endpackage

// ----- hdl/genotype_record_parser_core.sv -----
// genotype record parser
// input channel: one text byte per word (in_word_i), with a start-of-file mark
// that clears the parser and the sticky chromosome Y flag before that byte
// output channel: one record word per genotype line, emitted on the byte that
// carries the second allele; other bytes produce no output word
// throughput: one input word per cycle while the output register is not stalled; the per-byte state update
// is a single pass of logic between the input register and the output register
// path: the word holding a record's second allele is taken into the input register,
// parsed from there, and the record is then captured in the output register
// stall: when the output register holds a word that is not taken, the parser
// step freezes and in_ready_o falls once the input register is also full;
// an empty input register still takes one more word during a stall
// reset: rst_ni clears both registers' valid bits and puts the parser at
// line start with all record fields and the Y flag at zero
module genotype_record_parser_core
  import grp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_word_o
);

  logic      in_vld_q;
  in_word_t  in_word_q;
  logic      out_vld_q;
  out_word_t out_word_q;

  logic      advance;
  logic      step;
  logic      res_valid;
  out_word_t res_word;

  // output register is free or being drained this cycle
  assign advance    = !out_vld_q || out_ready_i;
  // parse the buffered byte whenever its result has a place to go
  assign step       = in_vld_q && advance;
  assign in_ready_o = !in_vld_q || advance;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_word_q <= in_word_i;
    end
  end

  // per-byte parser with its state
  grp_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .in_word_i   (in_word_q),
    .res_valid_o (res_valid),
    .res_word_o  (res_word)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= step && res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && res_valid) begin
      out_word_q <= res_word;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_word_o  = out_word_q;

endmodule

// ----- hdl/grp_parse.sv -----
module grp_parse
  import grp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_i,
  input  in_word_t  in_word_i,
  output logic      res_valid_o,
  output out_word_t res_word_o
);

  phase_e      phase_q, phase_d, eff_phase;
  logic [31:0] id_q, id_d, eff_id;
  logic        int_q, int_d, eff_int;
  logic [2:0]  kind_q, kind_d, eff_kind;
  logic [7:0]  num_q, num_d, eff_num;
  logic [31:0] pos_q, pos_d, eff_pos;
  logic [2:0]  first_q, first_d, eff_first;
  logic        yflag_q, yflag_d, eff_yflag;

  logic [7:0]  c;
  logic [3:0]  dig;
  logic        is_dig, is_wht;
  logic        do_chrom, do_al1;
  logic [11:0] num_wide;
  logic [2:0]  code_c;

  function automatic logic [2:0] allele_code(input logic [7:0] ch);
    logic [2:0] r;
    case (ch)
      CH_UP_A: r = ALLELE_A;
      CH_UP_C: r = ALLELE_C;
      CH_UP_D: r = ALLELE_D;
      CH_UP_G: r = ALLELE_G;
      CH_UP_I: r = ALLELE_I;
      CH_UP_T: r = ALLELE_T;
      default: r = ALLELE_NONE;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] times10_add(input logic [31:0] x, input logic [3:0] d);
    return (x << 3) + (x << 1) + {28'd0, d};
  endfunction

  assign c      = in_word_i.byte_req;
  assign dig    = c[3:0];
  assign is_dig = (c >= CH_ZERO) && (c <= CH_NINE);
  assign is_wht = (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
  assign code_c = allele_code(c);

  // start of file clears everything before this byte is parsed
  always_comb begin
    if (in_word_i.start_of_file) begin
      eff_phase = PH_LINE;
      eff_id    = '0;
      eff_int   = 1'b0;
      eff_kind  = KIND_NUM;
      eff_num   = '0;
      eff_pos   = '0;
      eff_first = ALLELE_NONE;
      eff_yflag = 1'b0;
    end else begin
      eff_phase = phase_q;
      eff_id    = id_q;
      eff_int   = int_q;
      eff_kind  = kind_q;
      eff_num   = num_q;
      eff_pos   = pos_q;
      eff_first = first_q;
      eff_yflag = yflag_q;
    end
  end

  assign num_wide = ({4'd0, eff_num} << 3) + ({4'd0, eff_num} << 1) + {8'd0, dig};

  always_comb begin
    phase_d     = eff_phase;
    id_d        = eff_id;
    int_d       = eff_int;
    kind_d      = eff_kind;
    num_d       = eff_num;
    pos_d       = eff_pos;
    first_d     = eff_first;
    yflag_d     = eff_yflag;
    do_chrom    = 1'b0;
    do_al1      = 1'b0;
    res_valid_o = 1'b0;

    case (eff_phase)
      PH_SKIPLINE: begin
        if (c == CH_LF) phase_d = PH_LINE;
      end
      PH_PREFIX: phase_d = PH_ID;
      PH_ID: begin
        if (is_dig) id_d = times10_add(eff_id, dig);
        else if (is_wht) phase_d = PH_WS1;
        else do_chrom = 1'b1;
      end
      PH_WS1: begin
        if (!is_wht) do_chrom = 1'b1;
      end
      PH_CHROM: do_chrom = 1'b1;
      PH_CHROMNUM: begin
        if (is_dig) num_d = (num_wide > 12'd255) ? 8'd255 : num_wide[7:0];
        else if (is_wht) phase_d = PH_WS2;
        else do_al1 = 1'b1;
      end
      PH_SKIPT: phase_d = PH_WS2;
      PH_WS2: begin
        if (is_dig) begin
          pos_d   = times10_add(eff_pos, dig);
          phase_d = PH_POS;
        end else if (!is_wht) begin
          do_al1 = 1'b1;
        end
      end
      PH_POS: begin
        if (is_dig) pos_d = times10_add(eff_pos, dig);
        else if (is_wht) phase_d = PH_WS3;
        else do_al1 = 1'b1;
      end
      PH_WS3: begin
        if (!is_wht) do_al1 = 1'b1;
      end
      PH_ALLELE1: do_al1 = 1'b1;
      PH_ALLELE2: begin
        if (eff_kind == KIND_Y) yflag_d = 1'b1;
        res_valid_o = 1'b1;
        phase_d     = PH_DISCARD;
      end
      PH_DISCARD: phase_d = PH_LINE;
      PH_END: phase_d = PH_END;
      default: begin
        // line start
        if (c == CH_LO_R || c == CH_LO_I) begin
          id_d    = '0;
          kind_d  = KIND_NUM;
          num_d   = '0;
          pos_d   = '0;
          first_d = ALLELE_NONE;
          int_d   = (c == CH_LO_I);
          phase_d = (c == CH_LO_I) ? PH_ID : PH_PREFIX;
        end else if (c == CH_NUL) begin
          phase_d = PH_END;
        end else if (c == CH_LF) begin
          phase_d = PH_LINE;
        end else begin
          phase_d = PH_SKIPLINE;
        end
      end
    endcase

    // chromosome field takes this byte
    if (do_chrom) begin
      if (is_dig) begin
        kind_d  = KIND_NUM;
        num_d   = {4'd0, dig};
        phase_d = PH_CHROMNUM;
      end else if (c == CH_UP_X) begin
        kind_d  = KIND_X;
        phase_d = PH_WS2;
      end else if (c == CH_UP_Y) begin
        kind_d  = KIND_Y;
        phase_d = PH_WS2;
      end else if (c == CH_UP_M) begin
        kind_d  = KIND_MT;
        phase_d = PH_SKIPT;
      end else begin
        kind_d  = KIND_UNK;
        phase_d = PH_WS2;
      end
    end

    // first allele takes this byte
    if (do_al1) begin
      first_d = code_c;
      phase_d = PH_ALLELE2;
    end
  end

  always_comb begin
    res_word_o.rsid              = eff_int ? (32'sd0 - $signed(eff_id)) : $signed(eff_id);
    res_word_o.is_internal       = eff_int;
    res_word_o.chromosome_kind   = eff_kind;
    res_word_o.chromosome_number = (eff_kind == KIND_NUM) ? eff_num : 8'd0;
    res_word_o.position          = eff_pos;
    res_word_o.allele_first      = eff_first;
    res_word_o.allele_second     = code_c;
    res_word_o.y_seen            = yflag_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_LINE;
      id_q    <= '0;
      int_q   <= 1'b0;
      kind_q  <= KIND_NUM;
      num_q   <= '0;
      pos_q   <= '0;
      first_q <= ALLELE_NONE;
      yflag_q <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      id_q    <= id_d;
      int_q   <= int_d;
      kind_q  <= kind_d;
      num_q   <= num_d;
      pos_q   <= pos_d;
      first_q <= first_d;
      yflag_q <= yflag_d;
    end
  end

endmodule
